// File: rtl/g711_cg_pkg.sv
// ----------------------------------------------------------------------------
// G.711 companded gain - shared package
// Register indexes, law codes and the expand/compress helpers.
// ----------------------------------------------------------------------------
package g711_cg_pkg;

  localparam int CodeW = 8;
  localparam int GainW = 16;
  localparam int MagW  = 15;
  localparam int ProdW = MagW + GainW;
  localparam int FracW = 12;
  localparam int CfgIdxW = 2;

  localparam logic [GainW-1:0] GAIN_UNITY = 16'd4096;
  localparam logic [MagW-1:0]  LIN_MAX    = 15'd32767;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_LAW_SELECT = 2'd0,
    CFG_GAIN_Q12   = 2'd1,
    CFG_BYPASS     = 2'd2
  } cfg_idx_t;

  typedef enum logic {
    LAW_MULAW = 1'b0,
    LAW_ALAW  = 1'b1
  } law_t;

  // code for linear zero in each law
  localparam logic [CodeW-1:0] MULAW_ZERO = 8'hFF;
  localparam logic [CodeW-1:0] ALAW_ZERO  = 8'hD5;

  typedef struct packed {
    logic            neg;
    logic [MagW-1:0] mag;
  } lin_t;

  // Expansion table, one entry per {law, code}
  function automatic lin_t g711_expand(input law_t law, input logic [CodeW-1:0] code);
    lin_t            r;
    logic [7:0]      u;
    logic [7:0]      a;
    logic [MagW-1:0] t;
    u = ~code;
    a = code ^ 8'h55;
    if (law == LAW_MULAW) begin
      t = MagW'({u[3:0], 3'b000}) + MagW'(8'h84);
      t = t << u[6:4];
      r.mag = t - MagW'(8'h84);
      r.neg = u[7];
    end else begin
      t = MagW'({a[3:0], 4'b0000});
      if (a[6:4] == 3'd0) begin
        t = t + MagW'(4'd8);
      end else begin
        t = (t + MagW'(9'h108)) << (a[6:4] - 3'd1);
      end
      r.mag = t;
      r.neg = ~a[7];
    end
    return r;
  endfunction

  // first segment s with p <= ((first_end+1) << s) - 1; 8 if none
  function automatic logic [3:0] find_seg(input logic [13:0] p, input logic [13:0] first_end);
    logic [3:0]  seg;
    logic [14:0] seg_end;
    seg = 4'd8;
    for (int s = 7; s >= 0; s--) begin
      seg_end = ((15'(first_end) + 15'd1) << s) - 15'd1;
      if (15'(p) <= seg_end) begin
        seg = 4'(s);
      end
    end
    return seg;
  endfunction

  function automatic logic [CodeW-1:0] mulaw_compress(input logic neg,
                                                      input logic [MagW-1:0] mag);
    logic [13:0]      p;
    logic [CodeW-1:0] mask;
    logic [3:0]       seg;
    logic [13:0]      sh;
    if (neg) begin
      p    = 14'((16'(mag) + 16'd3) >> 2);
      mask = 8'h7F;
    end else begin
      p    = 14'(mag >> 2);
      mask = 8'hFF;
    end
    if (p > 14'd8159) begin
      p = 14'd8159;
    end
    p   = p + 14'd33;
    seg = find_seg(p, 14'h3F);
    sh  = p >> (seg + 4'd1);
    if (seg[3]) begin
      return 8'h7F ^ mask;
    end
    return {1'b0, seg[2:0], sh[3:0]} ^ mask;
  endfunction

  function automatic logic [CodeW-1:0] alaw_compress(input logic neg,
                                                     input logic [MagW-1:0] mag);
    logic [13:0]      p;
    logic [CodeW-1:0] mask;
    logic [3:0]       seg;
    logic [13:0]      sh;
    if (neg) begin
      p    = 14'(((16'(mag) + 16'd7) >> 3) - 16'd1);
      mask = 8'h55;
    end else begin
      p    = 14'(mag >> 3);
      mask = 8'hD5;
    end
    seg = find_seg(p, 14'h1F);
    if (seg < 4'd2) begin
      sh = p >> 1;
    end else begin
      sh = p >> seg;
    end
    if (seg[3]) begin
      return 8'h7F ^ mask;
    end
    return {1'b0, seg[2:0], sh[3:0]} ^ mask;
  endfunction

endpackage

// File: rtl/g711_companded_gain_core.sv
// ----------------------------------------------------------------------------
// G.711 companded gain core
// Expand, scale by a Q4.12 gain with saturation, and re-compress G.711 bytes.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_ready carries one companded byte (code_in) per
//   item; output channel out_valid/out_ready carries the adjusted byte
//   (code_out). Config channel cfg_valid/cfg_ready with cfg_index/cfg_data
//   writes law_select (0), gain_q12 (1) and bypass (2); other indexes are
//   ignored. cfg_ready is always high. Write config only while idle.
//   Throughput is one item per cycle while the receiver does not stall: a
//   three-stage pipeline (expansion ROM read, 15x16 multiply,
//   shift/clamp/compress into the output register), the first stage
//   loading at the accepting edge.
//   The pipeline advances whenever the output register is empty or being
//   taken, so a stalled receiver holds every stage and deasserts in_ready;
//   items already inside are kept, none dropped.
//   Synchronous reset empties the pipeline and restores law_select = mu-law,
//   gain_q12 = 4096 (unity) and bypass = 1.
//   In bypass the byte passes through the same pipeline unchanged.
// ----------------------------------------------------------------------------
module g711_companded_gain_core
  import g711_cg_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  // config write channel
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [GainW-1:0]   cfg_data,
  // input items
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [CodeW-1:0]   code_in,
  // output items
  output logic               out_valid,
  input  logic               out_ready,
  output logic [CodeW-1:0]   code_out
);

  // config registers
  law_t             law_select;
  logic [GainW-1:0] gain_q12;
  logic             bypass;

  // pipeline control
  logic en;
  logic v1, v2;

  // stage 1: ROM read of the expansion table
  lin_t             lin1;
  logic [CodeW-1:0] code1;

  // stage 2: product
  logic [ProdW-1:0] prod2;
  logic             neg2;
  logic [CodeW-1:0] code2;

  // stage 3 combinational
  logic [ProdW-FracW-1:0] scaled;
  logic [MagW-1:0]        mag_sat;
  logic                   neg_sat;
  logic [CodeW-1:0]       code_next;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      law_select <= LAW_MULAW;
      gain_q12   <= GAIN_UNITY;
      bypass     <= 1'b1;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_LAW_SELECT: law_select <= law_t'(cfg_data[0]);
        CFG_GAIN_Q12:   gain_q12   <= cfg_data;
        CFG_BYPASS:     bypass     <= cfg_data[0];
        default: ;      // unknown index: ignored
      endcase
    end
  end

  // whole pipe moves when the output register is free or being drained
  assign en       = ~out_valid | out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1        <= in_valid;
      v2        <= v1;
      out_valid <= v2;
    end
  end

  // expansion ROM, registered read
  always_ff @(posedge clk) begin
    if (en) begin
      lin1  <= g711_expand(law_select, code_in);
      code1 <= code_in;
    end
  end

  // magnitude times gain, 15x16 bits
  always_ff @(posedge clk) begin
    if (en) begin
      prod2 <= ProdW'(lin1.mag) * ProdW'(gain_q12);
      neg2  <= lin1.neg;
      code2 <= code1;
    end
  end

  // truncate toward zero, clamp, drop sign of a zero result, compress (or pass the byte through in bypass)
  always_comb begin
    scaled = prod2[ProdW-1:FracW];
    if (scaled > (ProdW-FracW)'(LIN_MAX)) begin
      mag_sat = LIN_MAX;
    end else begin
      mag_sat = scaled[MagW-1:0];
    end
    neg_sat = neg2 & (mag_sat != '0);
    if (bypass) begin
      code_next = code2;
    end else if (law_select == LAW_ALAW) begin
      code_next = alaw_compress(neg_sat, mag_sat);
    end else begin
      code_next = mulaw_compress(neg_sat, mag_sat);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      code_out <= code_next;
    end
  end

`ifndef SYNTHESIS
  // an accepted item enters the first stage
  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> v1)
    else $error("accepted item did not enter stage 1");

  // a stalled product stage keeps its item
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    v2 && !en |=> v2 && $stable(prod2) && $stable(code2))
    else $error("stage 2 lost its item during a stall");

  // zero gain yields the code for linear zero
  a_zero_gain_mu: assert property (@(posedge clk) disable iff (rst)
    v2 && en && !bypass && gain_q12 == '0 && law_select == LAW_MULAW
      |=> code_out == MULAW_ZERO)
    else $error("mu-law zero gain gave a non-zero code");

  a_zero_gain_a: assert property (@(posedge clk) disable iff (rst)
    v2 && en && !bypass && gain_q12 == '0 && law_select == LAW_ALAW
      |=> code_out == ALAW_ZERO)
    else $error("A-law zero gain gave a non-zero code");
`endif

endmodule
